@@ design/ipv6_avl_pkg.sv @@
// Shared constants and error codes for the IPv6 address text validator.
`timescale 1ns / 1ps
package ipv6_avl_pkg;

  localparam int unsigned LenW    = 6;
  localparam int unsigned DigitW  = 6;
  localparam int unsigned GroupW  = 5;
  localparam int unsigned DotW    = 3;
  localparam int unsigned ErrW    = 4;

  localparam logic [LenW-1:0]   MinTextLen       = LenW'(2);
  localparam logic [DigitW-1:0] GroupHexMax      = DigitW'(4);
  localparam logic [GroupW-1:0] GroupsWithGapMax = GroupW'(7);
  localparam logic [GroupW-1:0] GroupsWithSuffix = GroupW'(6);
  localparam logic [GroupW-1:0] GroupsFull       = GroupW'(8);
  localparam logic [DotW-1:0]   SuffixDots       = DotW'(3);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam logic [ErrW-1:0] ErrNone        = 4'd0;
  localparam logic [ErrW-1:0] ErrLength      = 4'd1;
  localparam logic [ErrW-1:0] ErrTwoGaps     = 4'd2;
  localparam logic [ErrW-1:0] ErrGroupLong   = 4'd3;
  localparam logic [ErrW-1:0] ErrEmptyGroup  = 4'd4;
  localparam logic [ErrW-1:0] ErrDots        = 4'd5;
  localparam logic [ErrW-1:0] ErrSuffixNonde = 4'd6;
  localparam logic [ErrW-1:0] ErrBadChar     = 4'd7;
  localparam logic [ErrW-1:0] ErrLastLong    = 4'd8;
  localparam logic [ErrW-1:0] ErrSuffixDots  = 4'd9;
  localparam logic [ErrW-1:0] ErrTooMany     = 4'd10;
  localparam logic [ErrW-1:0] ErrGroupCount  = 4'd11;

  typedef struct packed {
    logic              ok;
    logic [ErrW-1:0]   code;
  } result_t;

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_decimal(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

@@ design/ipv6_address_text_validator.sv @@
// IPv6 address text validator: per-character checker with a two-entry result buffer.
//
// Input channel: one character per transfer (char_code_i), with last_char_i on the
// final character, or empty_text_i alone for an empty string (always valid).
// Output channel: one result per string, addr_valid_o and error_code_o
// (0 means accepted). Strings that do not end produce nothing.
// Throughput: one character per cycle while in_stall_o is low; the per-character
// check is a handful of compares and saturating counter updates done in the cycle
// the character is taken; its result goes to the result register or the skid entry.
// A result register plus one skid entry sit at the output: while the receiver
// stalls, the block keeps taking characters and only stalls its input once both
// entries hold results.
// Reset clears the string state and empties both result entries. Strings longer
// than MAX_TEXT_LEN characters or shorter than two report a length error.
`timescale 1ns / 1ps
module ipv6_address_text_validator
  import ipv6_avl_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = 45
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      char_code_i,
  input  logic            last_char_i,
  input  logic            empty_text_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            addr_valid_o,
  output logic [ErrW-1:0] error_code_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_TEXT_LEN);

  logic              colon_pending_q, colon_pending_d;
  logic [DigitW-1:0] group_digits_q, group_digits_d;
  logic [GroupW-1:0] group_total_q, group_total_d;
  logic              double_colon_q, double_colon_d;
  logic              dotted_q, dotted_d;
  logic [DotW-1:0]   dot_total_q, dot_total_d;
  logic [LenW-1:0]   text_length_q, text_length_d;
  logic [ErrW-1:0]   first_error_q, first_error_d;

  logic    in_xfer, res_new;
  result_t res;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign res_new    = in_xfer && (empty_text_i || last_char_i);

  always_comb begin
    logic              cp, dc, ds, stop;
    logic [DigitW-1:0] gd;
    logic [GroupW-1:0] gt;
    logic [DotW-1:0]   dt;
    logic [LenW-1:0]   len;
    logic [ErrW-1:0]   fe;
    cp   = colon_pending_q;
    gd   = group_digits_q;
    gt   = group_total_q;
    dc   = double_colon_q;
    ds   = dotted_q;
    dt   = dot_total_q;
    len  = text_length_q;
    fe   = first_error_q;
    stop = 1'b0;

    // length check comes first and overrides any earlier error
    if (len >= MaxLen) begin
      fe = ErrLength;
    end else begin
      len = len + LenW'(1);
    end

    // character step
    if (fe == ErrNone) begin
      if (char_code_i == ChColon) begin
        if (!cp) begin
          cp = 1'b1;
        end else begin
          cp = 1'b0;
          if (dc) begin
            fe = ErrTwoGaps;
          end else begin
            dc = 1'b1;
            if (gd > GroupHexMax) begin
              fe = ErrGroupLong;
            end else begin
              if (gd != '0 && gt != '1) gt = gt + GroupW'(1);
              gd = '0;
            end
          end
        end
      end else begin
        // resolve a colon that turned out to be single
        if (cp) begin
          cp = 1'b0;
          if (gd > GroupHexMax) begin
            fe = ErrGroupLong;
          end else if (gd == '0) begin
            fe = ErrEmptyGroup;
          end else begin
            if (gt != '1) gt = gt + GroupW'(1);
            gd = '0;
          end
          stop = (fe != ErrNone);
        end
        if (!stop) begin
          if (char_code_i == ChDot) begin
            ds = 1'b1;
            if (dt != '1) dt = dt + DotW'(1);
            if (dt > SuffixDots) fe = ErrDots;
          end else if (is_hex(char_code_i)) begin
            if (ds && !is_decimal(char_code_i)) begin
              fe = ErrSuffixNonde;
            end else if (gd != '1) begin
              gd = gd + DigitW'(1);
            end
          end else begin
            fe = ErrBadChar;
          end
        end
      end
    end

    // end-of-string checks
    if (last_char_i && fe == ErrNone) begin
      stop = 1'b0;
      if (cp) begin
        cp = 1'b0;
        if (gd > GroupHexMax) begin
          fe = ErrGroupLong;
        end else if (gd == '0) begin
          fe = ErrEmptyGroup;
        end else begin
          if (gt != '1) gt = gt + GroupW'(1);
          gd = '0;
        end
        stop = (fe != ErrNone);
      end
      if (!stop && gd != '0) begin
        if (!ds && gd > GroupHexMax) begin
          fe   = ErrLastLong;
          stop = 1'b1;
        end else if (gt != '1) begin
          gt = gt + GroupW'(1);
        end
      end
      if (!stop && ds && dt != SuffixDots) begin
        fe   = ErrSuffixDots;
        stop = 1'b1;
      end
      if (!stop) begin
        if (dc) begin
          if (gt > GroupsWithGapMax) fe = ErrTooMany;
        end else if (gt != (ds ? GroupsWithSuffix : GroupsFull)) begin
          fe = ErrGroupCount;
        end
      end
    end
    if (last_char_i && len < MinTextLen) fe = ErrLength;

    if (empty_text_i) begin
      res.ok   = 1'b1;
      res.code = ErrNone;
    end else begin
      res.ok   = (fe == ErrNone);
      res.code = fe;
    end

    // clear state after every result; hold it when nothing transfers
    if (!in_xfer) begin
      colon_pending_d = colon_pending_q;
      group_digits_d  = group_digits_q;
      group_total_d   = group_total_q;
      double_colon_d  = double_colon_q;
      dotted_d        = dotted_q;
      dot_total_d     = dot_total_q;
      text_length_d   = text_length_q;
      first_error_d   = first_error_q;
    end else if (empty_text_i || last_char_i) begin
      colon_pending_d = 1'b0;
      group_digits_d  = '0;
      group_total_d   = '0;
      double_colon_d  = 1'b0;
      dotted_d        = 1'b0;
      dot_total_d     = '0;
      text_length_d   = '0;
      first_error_d   = ErrNone;
    end else begin
      colon_pending_d = cp;
      group_digits_d  = gd;
      group_total_d   = gt;
      double_colon_d  = dc;
      dotted_d        = ds;
      dot_total_d     = dt;
      text_length_d   = len;
      first_error_d   = fe;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colon_pending_q <= 1'b0;
      group_digits_q  <= '0;
      group_total_q   <= '0;
      double_colon_q  <= 1'b0;
      dotted_q        <= 1'b0;
      dot_total_q     <= '0;
      text_length_q   <= '0;
      first_error_q   <= ErrNone;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      colon_pending_q <= colon_pending_d;
      group_digits_q  <= group_digits_d;
      group_total_q   <= group_total_d;
      double_colon_q  <= double_colon_d;
      dotted_q        <= dotted_d;
      dot_total_q     <= dot_total_d;
      text_length_q   <= text_length_d;
      first_error_q   <= first_error_d;
      if (out_free) begin
        out_valid_q  <= skid_valid_q || res_new;
        skid_valid_q <= 1'b0;
      end else if (res_new) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload: advance from skid first, park a new result in skid while stalled
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_new) begin
        out_q <= res;
      end
    end else if (res_new) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign addr_valid_o = out_q.ok;
  assign error_code_o = out_q.code;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_ok_matches_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.ok == (out_q.code == ErrNone)))
    else $error("addr_valid disagrees with error code");

  a_len_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_length_q <= MaxLen)
    else $error("text length counter past its limit");

  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_new |=> (text_length_q == '0 && first_error_q == ErrNone))
    else $error("string state not cleared after result");

endmodule

@@ tb/ipv6_address_text_validator_tb.sv @@
// Self-checking testbench for the IPv6 address text validator.
`timescale 1ns / 1ps
module ipv6_address_text_validator_tb;
  import ipv6_avl_pkg::*;

  localparam int unsigned TextLenMax = 45;
  localparam int ProbeRows  = 21;
  localparam int HoldCycles = 200;
  localparam int QuietLimit = 1000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      char_code_i;
  logic            last_char_i;
  logic            empty_text_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic            addr_valid_o;
  logic [ErrW-1:0] error_code_o;

  ipv6_address_text_validator #(
    .MAX_TEXT_LEN (TextLenMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .empty_text_i (empty_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .addr_valid_o (addr_valid_o),
    .error_code_o (error_code_o)
  );

  typedef struct packed {
    logic              colon_wait;
    logic [DigitW-1:0] hex_run;
    logic [GroupW-1:0] groups;
    logic              gap_seen;
    logic              dotted;
    logic [DotW-1:0]   dots;
    logic [LenW-1:0]   len;
    logic [ErrW-1:0]   err;
  } scan_t;

  // one directed item; pin marks a row whose verdict is typed in below
  typedef struct packed {
    logic [7:0]      ch;
    logic            lst;
    logic            emp;
    logic            pin;
    logic [ErrW-1:0] code;
  } probe_t;

  scan_t      scan;
  result_t    verdict_q[$];
  logic [7:0] text_q[$];
  int         items_sent;
  int         fault_count;
  int         quiet_cycles;
  bit         idle_on;
  bit         hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void note_fault(input logic [ErrW-1:0] code);
    if (scan.err == ErrNone) scan.err = code;
  endfunction

  function automatic void add_group();
    if (scan.groups != '1) scan.groups = scan.groups + GroupW'(1);
  endfunction

  // close a group ended by a lone colon
  function automatic void end_group();
    scan.colon_wait = 1'b0;
    if (scan.hex_run > GroupHexMax) begin
      note_fault(ErrGroupLong);
    end else if (scan.hex_run == '0) begin
      note_fault(ErrEmptyGroup);
    end else begin
      add_group();
      scan.hex_run = '0;
    end
  endfunction

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic hexa_char(input logic [7:0] c);
    return dec_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    if (c == ChColon) begin
      // hold the first colon until the next character tells single from double
      if (!scan.colon_wait) begin
        scan.colon_wait = 1'b1;
        return;
      end
      scan.colon_wait = 1'b0;
      if (scan.gap_seen) begin
        note_fault(ErrTwoGaps);
        return;
      end
      scan.gap_seen = 1'b1;
      if (scan.hex_run > GroupHexMax) begin
        note_fault(ErrGroupLong);
        return;
      end
      if (scan.hex_run != '0) add_group();
      scan.hex_run = '0;
      return;
    end
    if (scan.colon_wait) begin
      end_group();
      if (scan.err != ErrNone) return;
    end
    if (c == ChDot) begin
      scan.dotted = 1'b1;
      if (scan.dots != '1) scan.dots = scan.dots + DotW'(1);
      if (scan.dots > SuffixDots) note_fault(ErrDots);
    end else if (hexa_char(c)) begin
      if (scan.dotted && !dec_char(c)) begin
        note_fault(ErrSuffixNonde);
        return;
      end
      if (scan.hex_run != '1) scan.hex_run = scan.hex_run + DigitW'(1);
    end else begin
      note_fault(ErrBadChar);
    end
  endfunction

  function automatic void close_text();
    if (scan.colon_wait) begin
      end_group();
      if (scan.err != ErrNone) return;
    end
    if (scan.hex_run != '0) begin
      if (!scan.dotted && (scan.hex_run > GroupHexMax)) begin
        note_fault(ErrLastLong);
        return;
      end
      add_group();
    end
    if (scan.dotted && (scan.dots != SuffixDots)) begin
      note_fault(ErrSuffixDots);
      return;
    end
    if (scan.gap_seen) begin
      if (scan.groups > GroupsWithGapMax) note_fault(ErrTooMany);
    end else if (scan.groups != (scan.dotted ? GroupsWithSuffix : GroupsFull)) begin
      note_fault(ErrGroupCount);
    end
  endfunction

  // advance the model by one accepted character; 1 when a verdict is due
  function automatic logic predict_verdict(input logic [7:0] c, input logic lst,
                                           input logic emp, output result_t res);
    res = '0;
    if (emp) begin
      scan = '0;
      res.ok = 1'b1;
      res.code = ErrNone;
      return 1'b1;
    end
    if (scan.len >= TextLenMax) scan.err = ErrLength;
    else scan.len = scan.len + LenW'(1);
    if (scan.err == ErrNone) scan_char(c);
    if (!lst) return 1'b0;
    if (scan.err == ErrNone) close_text();
    // length error outranks whatever came earlier
    if (scan.len < MinTextLen) scan.err = ErrLength;
    res.ok = (scan.err == ErrNone);
    res.code = scan.err;
    scan = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic probe_t probe_row(input int idx);
    //                ch       lst   emp   pin   verdict
    case (idx)
      0:  return {8'hFF,   1'b1, 1'b1, 1'b1, ErrNone};     // empty string
      1:  return {ChColon, 1'b0, 1'b0, 1'b0, ErrNone};
      2:  return {ChColon, 1'b1, 1'b0, 1'b0, ErrNone};
      3:  return {8'("a"), 1'b1, 1'b0, 1'b1, ErrLength};   // one character
      4:  return {8'h00,   1'b0, 1'b0, 1'b0, ErrNone};
      5:  return {8'("1"), 1'b1, 1'b0, 1'b1, ErrBadChar};  // byte zero
      6:  return {8'hFF,   1'b0, 1'b0, 1'b0, ErrNone};
      7:  return {8'("7"), 1'b1, 1'b0, 1'b1, ErrBadChar};  // non-ASCII byte
      8:  return {8'("1"), 1'b0, 1'b0, 1'b0, ErrNone};
      9:  return {8'("2"), 1'b0, 1'b0, 1'b0, ErrNone};
      10: return {8'h00,   1'b0, 1'b1, 1'b1, ErrNone};     // empty mark mid-string
      11: return {8'("1"), 1'b0, 1'b0, 1'b0, ErrNone};
      12: return {ChColon, 1'b1, 1'b0, 1'b0, ErrNone};     // trailing colon
      13: return {8'("1"), 1'b0, 1'b0, 1'b0, ErrNone};
      14: return {ChDot,   1'b0, 1'b0, 1'b0, ErrNone};
      15: return {8'("f"), 1'b1, 1'b0, 1'b0, ErrNone};
      16: return {ChColon, 1'b0, 1'b0, 1'b0, ErrNone};
      17: return {ChColon, 1'b0, 1'b0, 1'b0, ErrNone};
      18: return {ChColon, 1'b1, 1'b0, 1'b0, ErrNone};
      19: return {ChDot,   1'b0, 1'b0, 1'b0, ErrNone};
      20: return {ChDot,   1'b1, 1'b0, 1'b0, ErrNone};
      default: return '0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return hex_char();
      4, 5:       return ChColon;
      6:          return ChDot;
      7:          return 8'("0" + $urandom_range(0, 9));
      8:          return 8'($urandom_range(0, 255));
      default:    return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // push one hex group, now and then longer than four digits
  function automatic void append_hex();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    repeat (n) text_q.push_back(hex_char());
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_item(input logic [7:0] c, input logic lst, input logic emp,
                            input logic pin, input logic [ErrW-1:0] pin_code);
    result_t res;
    if (idle_on && ($urandom_range(0, 4) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= c;
    last_char_i  <= lst;
    empty_text_i <= emp;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (predict_verdict(c, lst, emp, res)) begin
      if (pin) begin
        res.ok = (pin_code == ErrNone);
        res.code = pin_code;
      end
      verdict_q.push_back(res);
    end
    @(negedge clk_i);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int kind;
    int n_pre;
    int n_post;
    int pos;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      text_q.delete();
      if (kind < 25) begin
        // full form, mostly eight groups
        n_pre = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 9) : 8;
        for (int g = 0; g < n_pre; g++) begin
          if (g != 0) text_q.push_back(ChColon);
          append_hex();
        end
      end else if (kind < 45) begin
        // compressed form, group total may overrun by one
        n_pre  = $urandom_range(0, 7);
        n_post = $urandom_range(0, 8 - n_pre);
        for (int g = 0; g < n_pre; g++) begin
          if (g != 0) text_q.push_back(ChColon);
          append_hex();
        end
        text_q.push_back(ChColon);
        text_q.push_back(ChColon);
        for (int g = 0; g < n_post; g++) begin
          if (g != 0) text_q.push_back(ChColon);
          append_hex();
        end
      end else if (kind < 60) begin
        // dotted suffix after six groups or after a gap
        if ($urandom_range(0, 1) == 1) begin
          repeat (6) begin
            append_hex();
            text_q.push_back(ChColon);
          end
        end else begin
          n_pre  = $urandom_range(0, 4);
          n_post = $urandom_range(0, 4 - n_pre);
          for (int g = 0; g < n_pre; g++) begin
            if (g != 0) text_q.push_back(ChColon);
            append_hex();
          end
          text_q.push_back(ChColon);
          text_q.push_back(ChColon);
          repeat (n_post) begin
            append_hex();
            text_q.push_back(ChColon);
          end
        end
        n_pre = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 5) : 4;
        for (int g = 0; g < n_pre; g++) begin
          if (g != 0) text_q.push_back(ChDot);
          repeat ($urandom_range(1, 3)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end else if (kind < 72) begin
        repeat ($urandom_range(1, 14)) text_q.push_back(noise_char());
      end else if (kind < 82) begin
        // long texts around the length limit
        n_pre = ($urandom_range(0, 1) == 1) ? $urandom_range(43, 48) : $urandom_range(30, 63);
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(ChColon);
          text_q.push_back(ChColon);
        end
        while (text_q.size() < n_pre)
          text_q.push_back((text_q.size() % 5 == 4) ? ChColon : hex_char());
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(noise_char());
      end
      // break some of the well-formed texts
      if ((kind < 60) && ($urandom_range(0, 9) < 3)) begin
        repeat ($urandom_range(1, 2)) begin
          if (text_q.size() == 0) text_q.push_back(noise_char());
          pos = $urandom_range(0, text_q.size() - 1);
          case ($urandom_range(0, 3))
            0:       text_q[pos] = noise_char();
            1:       text_q.delete(pos);
            2:       text_q.insert(pos, ChColon);
            default: text_q.insert(pos, hex_char());
          endcase
        end
      end
      if (text_q.size() == 0)
        offer_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, ErrNone);
      for (int i = 0; i < text_q.size(); i++) begin
        // drop the partial text now and then
        if ((i > 0) && ($urandom_range(0, 49) == 0))
          offer_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0,
                     ErrNone);
        offer_item(text_q[i], (i == text_q.size() - 1), 1'b0, 1'b0, ErrNone);
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end else if ((stall_left == 0) && idle_on && ($urandom_range(0, 4) == 0)) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fault_count++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer, addr_valid %b error_code %0d",
                                addr_valid_o, error_code_o));
      end else begin
        want = verdict_q.pop_front();
        if (addr_valid_o !== want.ok)
          flag_mismatch($sformatf("addr_valid %b, want %b", addr_valid_o, want.ok));
        if (error_code_o !== want.code)
          flag_mismatch($sformatf("error_code %0d, want %0d", error_code_o, want.code));
      end
    end
  end

  // end the run when no transfer happens on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    probe_t row;
    in_valid_i   = 1'b0;
    char_code_i  = '0;
    last_char_i  = 1'b0;
    empty_text_i = 1'b0;
    rst_ni       = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    scan         = '0;
    items_sent   = 0;
    fault_count  = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < ProbeRows; r++) begin
      row = probe_row(r);
      offer_item(row.ch, row.lst, row.emp, row.pin, row.code);
    end
    run_random(450);

    // drain, then stall the output long enough to back up the input
    in_valid_i <= 1'b0;
    wait (verdict_q.size() == 0);
    @(negedge clk_i);
    hold_req = 1'b1;
    run_random(450);

    in_valid_i <= 1'b0;
    wait (verdict_q.size() == 0);
    @(negedge clk_i);
    idle_on = 1'b0;
    run_random(200);

    in_valid_i <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
